/* sv/cbb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the cursor byte buffer.
package cbb_pkg;

    localparam int CW   = 11;   // cursor, count and config register width
    localparam int IW   = 16;   // index / count field width
    localparam int DW   = 32;   // data word width
    localparam int CMDW = 4;

    typedef enum logic [CMDW-1:0] {
        CMD_RESTART     = 4'd0,
        CMD_GET         = 4'd1,
        CMD_SET         = 4'd2,
        CMD_WRITE_BYTE  = 4'd3,
        CMD_WRITE_WORD  = 4'd4,
        CMD_WRITE_JUMP  = 4'd5,
        CMD_READ_JUMP   = 4'd6,
        CMD_READ_BYTE   = 4'd7,
        CMD_READ_WORD16 = 4'd8,
        CMD_READ_WORD32 = 4'd9,
        CMD_STATUS      = 4'd10
    } t_cmd;

    localparam logic [1:0] REG_BUFFER_SIZE  = 2'd0;
    localparam logic [1:0] REG_BASE_OFFSET  = 2'd1;
    localparam logic [1:0] REG_INITIAL_FILL = 2'd2;

    localparam logic [CW-1:0] RST_BUFFER_SIZE  = 11'd1024;
    localparam logic [CW-1:0] RST_BASE_OFFSET  = 11'd0;
    localparam logic [CW-1:0] RST_INITIAL_FILL = 11'd0;

    // effective geometry derived from the config registers
    typedef struct packed {
        logic [CW-1:0] size;
        logic [CW-1:0] off;
        logic [CW-1:0] lim;
    } t_geom;

endpackage

/* sv/cursor_byte_buffer.sv */
`timescale 1ns / 1ps
// Linear byte buffer with read and write cursors, stored in four byte banks.
// The result strobe is registered in S_FIN; no new start is taken until it is out.
// The banks are read or written at the accept edge; counts and read data are formed next cycle.
// The receiver cannot stall: o_valid is high for one cycle per item.
// Reset: config registers return to defaults and cursors to zero, then a clearing pass
// zeroes the store, one row of four bytes a cycle, with busy high.
module cursor_byte_buffer #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic [cbb_pkg::CMDW-1:0] i_command,
    input  logic [cbb_pkg::IW-1:0]   i_index_or_count,
    input  logic [cbb_pkg::DW-1:0]   i_data_in,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [cbb_pkg::CW-1:0]   i_cfg_data,
    output logic                     busy,
    output logic                     o_valid,
    output logic                     o_ok,
    output logic [cbb_pkg::DW-1:0]   o_read_value,
    output logic [cbb_pkg::CW-1:0]   o_unread_count,
    output logic [cbb_pkg::CW-1:0]   o_free_count
);

    localparam int CW   = cbb_pkg::CW;
    localparam int ROWS = (STORE_DEPTH + 3) / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LA   = 17;   // byte address: 16-bit index plus offset
    localparam logic [LA-1:0] DEPTH_L  = LA'(STORE_DEPTH);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_FIN} t_state;

    function automatic cbb_pkg::t_geom geom(input logic [CW-1:0] bsize,
                                            input logic [CW-1:0] bbase);
        cbb_pkg::t_geom g;
        g.size = (32'(bsize) < STORE_DEPTH) ? bsize : CW'(STORE_DEPTH);
        g.off  = (bbase < g.size) ? bbase : g.size;
        g.lim  = g.size - g.off;
        return g;
    endfunction

    // advance a cursor, saturating at the top; returns {ok, new cursor}
    function automatic logic [CW:0] jump(input logic [CW-1:0] cur,
                                         input logic [cbb_pkg::IW-1:0] n,
                                         input cbb_pkg::t_geom g);
        logic [17:0] tot;
        tot = 18'(cur) + 18'(n) + 18'(g.off);
        if (tot >= 18'(g.size))
            return {1'b0, g.lim};
        return {1'b1, CW'(18'(cur) + 18'(n))};
    endfunction

    t_state          r_state;
    logic [RW-1:0]   r_clr_row;
    logic [CW-1:0]   r_bsize, r_bbase, r_fill;
    logic [CW-1:0]   n_bsize, n_bbase, n_fill;
    cbb_pkg::t_geom  r_geom;
    logic [CW-1:0]   r_rc, r_wc, n_rc, n_wc;
    logic            r_ok_p;
    logic [2:0]      r_nrd;
    logic [1:0]      r_lo;
    logic [3:0]      r_bval;
    logic [7:0]      r_rd [4];

    logic            accept;
    logic            ok;
    logic [2:0]      nrd, nwr;
    logic [LA-1:0]   ba, gaddr, waddr, raddr;
    logic [31:0]     wword;
    logic [3:0]      bval;
    logic            mem_we   [4];
    logic [RW-1:0]   mem_wrow [4];
    logic [7:0]      mem_wd   [4];
    logic [RW-1:0]   mem_rrow [4];
    logic [31:0]     rd_value;
    logic [CW-1:0]   unread, free;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);

    always_comb begin
        n_bsize = r_bsize;
        n_bbase = r_bbase;
        n_fill  = r_fill;
        if (i_cfg_we) begin
            if (i_cfg_index == cbb_pkg::REG_BUFFER_SIZE)  n_bsize = i_cfg_data;
            if (i_cfg_index == cbb_pkg::REG_BASE_OFFSET)  n_bbase = i_cfg_data;
            if (i_cfg_index == cbb_pkg::REG_INITIAL_FILL) n_fill  = i_cfg_data;
        end
    end

    // command decode and cursor update
    always_comb begin
        gaddr = LA'(i_index_or_count) + LA'(r_geom.off);
        waddr = LA'(r_wc) + LA'(r_geom.off);
        raddr = LA'(r_rc) + LA'(r_geom.off);
        n_rc  = r_rc;
        n_wc  = r_wc;
        ok    = 1'b0;
        nrd   = 3'd0;
        nwr   = 3'd0;
        ba    = raddr;
        wword = {i_data_in[7:0], 24'h0};
        case (cbb_pkg::t_cmd'(i_command))
            cbb_pkg::CMD_RESTART: begin
                n_rc = '0;
                n_wc = (12'(r_fill) + 12'(r_geom.off) >= 12'(r_geom.size)) ? r_geom.lim
                                                                            : r_fill;
                ok   = 1'b1;
            end
            cbb_pkg::CMD_GET: begin
                ba = gaddr;
                if (gaddr < LA'(r_geom.size)) begin
                    ok  = 1'b1;
                    nrd = 3'd1;
                end
            end
            cbb_pkg::CMD_SET: begin
                ba = gaddr;
                if (gaddr < LA'(r_geom.size)) begin
                    ok  = 1'b1;
                    nwr = 3'd1;
                end
            end
            cbb_pkg::CMD_WRITE_BYTE: begin
                ba = waddr;
                if (r_wc < r_geom.lim) begin
                    nwr  = 3'd1;
                    n_wc = r_wc + CW'(1);
                    ok   = 1'b1;
                end
            end
            cbb_pkg::CMD_WRITE_WORD: begin
                ba    = waddr;
                wword = i_data_in;
                if (12'(r_wc) + 12'd4 <= 12'(r_geom.lim)) begin
                    nwr        = 3'd4;
                    {ok, n_wc} = jump(r_wc, 16'd4, r_geom);
                end
            end
            cbb_pkg::CMD_WRITE_JUMP: {ok, n_wc} = jump(r_wc, i_index_or_count, r_geom);
            cbb_pkg::CMD_READ_JUMP:  {ok, n_rc} = jump(r_rc, i_index_or_count, r_geom);
            cbb_pkg::CMD_READ_BYTE: begin
                if (12'(r_rc) + 12'd1 <= 12'(r_wc)) begin
                    nrd  = 3'd1;
                    n_rc = r_rc + CW'(1);
                    ok   = 1'b1;
                end
            end
            cbb_pkg::CMD_READ_WORD16: begin
                if (12'(r_rc) + 12'd2 <= 12'(r_wc)) begin
                    nrd        = 3'd2;
                    {ok, n_rc} = jump(r_rc, 16'd2, r_geom);
                end
            end
            cbb_pkg::CMD_READ_WORD32: begin
                if (12'(r_rc) + 12'd4 <= 12'(r_wc)) begin
                    nrd        = 3'd4;
                    {ok, n_rc} = jump(r_rc, 16'd4, r_geom);
                end
            end
            cbb_pkg::CMD_STATUS: ok = 1'b1;
            default: ok = 1'b0;
        endcase
    end

    // bank b holds byte k = b - ba[1:0] of the access; bytes past the store are dropped
    always_comb begin
        logic [1:0]    k;
        logic [LA-1:0] a;
        logic [31:0]   sh;
        for (int b = 0; b < 4; b++) begin
            k  = 2'(b) - ba[1:0];
            a  = ba + LA'(k);
            sh = wword << {k, 3'b000};
            mem_rrow[b] = a[RW+1:2];
            if (r_state == S_CLEAR) begin
                mem_we[b]   = 1'b1;
                mem_wrow[b] = r_clr_row;
                mem_wd[b]   = 8'h00;
            end else begin
                mem_we[b]   = accept && (3'(k) < nwr) && (a < DEPTH_L);
                mem_wrow[b] = a[RW+1:2];
                mem_wd[b]   = sh[31:24];
            end
        end
        for (int j = 0; j < 4; j++) begin
            a       = ba + LA'(j);
            bval[j] = (3'(j) < nrd) && (a < DEPTH_L);
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] mem [ROWS];
        always_ff @(posedge i_clk) begin
            if (mem_we[b])
                mem[mem_wrow[b]] <= mem_wd[b];
            if (accept)
                r_rd[b] <= mem[mem_rrow[b]];
        end
    end

    // big-endian assembly of the fetched bytes, counts from the updated cursors
    always_comb begin
        logic [1:0] sel;
        rd_value = '0;
        for (int k = 0; k < 4; k++) begin
            sel = r_lo + 2'(k);
            if (3'(k) < r_nrd)
                rd_value = {rd_value[23:0], r_bval[k] ? r_rd[sel] : 8'h00};
        end
        unread = (r_wc > r_rc) ? r_wc - r_rc : '0;
        free   = (r_wc < r_geom.lim) ? r_geom.lim - r_wc : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
            r_bsize   <= cbb_pkg::RST_BUFFER_SIZE;
            r_bbase   <= cbb_pkg::RST_BASE_OFFSET;
            r_fill    <= cbb_pkg::RST_INITIAL_FILL;
            r_geom    <= geom(cbb_pkg::RST_BUFFER_SIZE, cbb_pkg::RST_BASE_OFFSET);
            r_rc      <= '0;
            r_wc      <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_bsize <= n_bsize;
            r_bbase <= n_bbase;
            r_fill  <= n_fill;
            r_geom  <= geom(n_bsize, n_bbase);
            o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_row <= r_clr_row + RW'(1);
                    if (r_clr_row == LAST_ROW)
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_rc    <= n_rc;
                        r_wc    <= n_wc;
                        r_ok_p  <= ok;
                        r_nrd   <= nrd;
                        r_lo    <= ba[1:0];
                        r_bval  <= bval;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    o_valid        <= 1'b1;
                    o_ok           <= r_ok_p;
                    o_read_value   <= rd_value;
                    o_unread_count <= unread;
                    o_free_count   <= free;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
